// ===== rtl/core/conv3x3_zero_border_filter_core_macros.svh =====
//------------------------------------------------------------------------------
// 3x3 convolution filter: assertion macros
// Shared assertion shorthands for the filter core checker. Each use expects
// signals named clk and rst_n in the enclosing scope.
//------------------------------------------------------------------------------
`ifndef CONV3X3_ZERO_BORDER_FILTER_CORE_MACROS_SVH
`define CONV3X3_ZERO_BORDER_FILTER_CORE_MACROS_SVH

// Concurrent check on the rising clock edge, masked while reset is asserted.
`define C3ZB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// While a beat is offered and not taken, the given expression must hold next cycle.
`define C3ZB_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
    `C3ZB_ASSERT(lbl, (vld) && !(rdy) |=> (sig), msg)

`endif

// ===== rtl/core/c3zb_pkg.sv =====
//------------------------------------------------------------------------------
// 3x3 convolution filter: shared package
// Widths, register codes and types used across the filter core.
//------------------------------------------------------------------------------
package c3zb_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int COL_W          = $clog2(MAX_WIDTH);
    localparam int WEFF_W         = $clog2(MAX_WIDTH + 1);
    localparam int WIDTH_W        = 11;
    localparam int HEIGHT_W       = 12;
    localparam int PIX_W          = 8;
    localparam int LB_W           = 2 * PIX_W;
    localparam int COEF_W         = 16;
    localparam int COEF_FRAC_BITS = 8;
    localparam int TAPS           = 3;
    localparam int ROW_COEF_W     = TAPS * COEF_W;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 48;
    localparam int PROD_W         = COEF_W + PIX_W + 1;
    localparam int ROWSUM_W       = PROD_W + 2;
    localparam int SUM_W          = PROD_W + 4;
    localparam int FIFO_DEPTH     = 8;
    localparam int FIFO_AW        = $clog2(FIFO_DEPTH);
    localparam int CRED_W         = $clog2(FIFO_DEPTH + 1);

    localparam logic [WIDTH_W-1:0]    FRAME_WIDTH_RST  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0]   FRAME_HEIGHT_RST = HEIGHT_W'(480);
    localparam logic [ROW_COEF_W-1:0] COEF_TOP_RST     = '0;
    localparam logic [ROW_COEF_W-1:0] COEF_MIDDLE_RST  = ROW_COEF_W'(48'h0000_0100_0000);
    localparam logic [ROW_COEF_W-1:0] COEF_BOTTOM_RST  = '0;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_COEF_TOP     = 3'd2,
        REG_COEF_MIDDLE  = 3'd3,
        REG_COEF_BOTTOM  = 3'd4
    } cfg_reg_t;

    // Per-item control that travels with the pixel into the window datapath.
    typedef struct packed {
        logic emit;
        logic last;
        logic row_hi_ok;
        logic row_lo_ok;
        logic col_hi_ok;
        logic col_lo_ok;
    } tap_ctl_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } out_beat_t;

    // Entry 0 is the oldest row, entry TAPS-1 the newest.
    typedef logic [TAPS-1:0][PIX_W-1:0]      tap_col_t;
    typedef logic [TAPS-1:0][ROW_COEF_W-1:0] coef_rows_t;

endpackage

// ===== rtl/core/c3zb_ifs.sv =====
//------------------------------------------------------------------------------
// 3x3 convolution filter: channel interfaces
// Valid/ready channels for input pixels, filtered pixels and register writes.
//------------------------------------------------------------------------------
interface c3zb_pix_in_if;
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic [c3zb_pkg::PIX_W-1:0] pixel_in;

    modport source (output valid, output cmd, output pixel_in, input ready);
    modport sink   (input valid, input cmd, input pixel_in, output ready);
endinterface

interface c3zb_pix_out_if;
    logic                       valid;
    logic                       ready;
    logic [c3zb_pkg::PIX_W-1:0] pixel_out;
    logic                       frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

interface c3zb_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [c3zb_pkg::CFG_IDX_W-1:0]  index;
    logic [c3zb_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/c3zb_line_buf.sv =====
//------------------------------------------------------------------------------
// 3x3 convolution filter: line buffer
// One entry per column holding the two previous rows; one read and one write
// per cycle, registered read with write-to-read bypass on the same column.
//------------------------------------------------------------------------------
module c3zb_line_buf (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [c3zb_pkg::COL_W-1:0] rd_addr,
    input  logic                       wr_en,
    input  logic [c3zb_pkg::COL_W-1:0] wr_addr,
    input  logic [c3zb_pkg::LB_W-1:0]  wr_data,
    output logic [c3zb_pkg::LB_W-1:0]  rd_data
);

    logic [c3zb_pkg::LB_W-1:0] mem [c3zb_pkg::MAX_WIDTH];
    logic [c3zb_pkg::LB_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // With a one-column frame the write of one pixel and the read of the
    // next hit the same entry in the same cycle.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/c3zb_ctrl.sv =====
//------------------------------------------------------------------------------
// 3x3 convolution filter: position control
// Tracks input and output frame positions, derives border masks and the
// output credit count that gates input ready.
//------------------------------------------------------------------------------
module c3zb_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          geom_wr,
    input  logic                          pop,
    input  logic [c3zb_pkg::WEFF_W-1:0]   w_eff,
    input  logic [c3zb_pkg::HEIGHT_W-1:0] h_eff,
    output logic                          ready,
    output logic [c3zb_pkg::COL_W-1:0]    rd_col,
    output c3zb_pkg::tap_ctl_t            ctl
);

    localparam int COL_W    = c3zb_pkg::COL_W;
    localparam int WEFF_W   = c3zb_pkg::WEFF_W;
    localparam int HEIGHT_W = c3zb_pkg::HEIGHT_W;
    localparam int CRED_W   = c3zb_pkg::CRED_W;

    logic [COL_W-1:0]    in_col_reg,  in_col_next;
    logic [1:0]          in_row_reg,  in_row_next;
    logic [HEIGHT_W-1:0] out_row_reg, out_row_next;
    logic [COL_W-1:0]    out_col_reg, out_col_next;
    logic [CRED_W-1:0]   credit_reg,  credit_next;

    logic [WEFF_W-1:0]   in_col_inc;
    logic [WEFF_W-1:0]   out_col_inc;
    logic [HEIGHT_W:0]   out_row_inc;
    logic                last_col;
    logic                last_row;

    always_comb
    begin
        in_col_inc  = {1'b0, in_col_reg} + WEFF_W'(1);
        out_col_inc = {1'b0, out_col_reg} + WEFF_W'(1);
        out_row_inc = {1'b0, out_row_reg} + (HEIGHT_W + 1)'(1);
        last_col    = (out_col_inc >= w_eff);
        last_row    = (out_row_inc >= {1'b0, h_eff});

        // The input runs one row and one column ahead of the output.
        ctl.emit      = (in_row_reg == 2'd2) || ((in_row_reg == 2'd1) && (in_col_reg != '0));
        ctl.last      = last_row && last_col;
        ctl.row_hi_ok = !last_row;
        ctl.row_lo_ok = (out_row_reg != '0);
        ctl.col_hi_ok = !last_col;
        ctl.col_lo_ok = (out_col_reg != '0);

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;

        if (geom_wr)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (accept)
        begin
            if (in_col_inc >= w_eff)
            begin
                in_col_next = '0;
                in_row_next = (in_row_reg == 2'd2) ? 2'd2 : in_row_reg + 2'd1;
            end
            else
            begin
                in_col_next = in_col_inc[COL_W-1:0];
            end

            if (ctl.emit)
            begin
                if (ctl.last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (last_col)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_inc[HEIGHT_W-1:0];
                end
                else
                begin
                    out_col_next = out_col_inc[COL_W-1:0];
                end
            end
        end

        credit_next = credit_reg + CRED_W'(accept && ctl.emit) - CRED_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            credit_reg  <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            credit_reg  <= credit_next;
        end
    end

    assign ready  = (credit_reg < CRED_W'(c3zb_pkg::FIFO_DEPTH));
    assign rd_col = in_col_reg;

endmodule

// ===== rtl/core/c3zb_mac.sv =====
//------------------------------------------------------------------------------
// 3x3 convolution filter: window and multiply-accumulate
// Holds the 3x3 window, forms nine masked products, sums them over two
// registered levels and saturates the scaled sum to a pixel.
//------------------------------------------------------------------------------
module c3zb_mac (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift_en,
    input  c3zb_pkg::tap_col_t   col_in,
    input  c3zb_pkg::tap_ctl_t   ctl_in,
    input  c3zb_pkg::coef_rows_t coef_rows,
    output logic                 push,
    output c3zb_pkg::out_beat_t  beat
);

    localparam int TAPS     = c3zb_pkg::TAPS;
    localparam int PIX_W    = c3zb_pkg::PIX_W;
    localparam int COEF_W   = c3zb_pkg::COEF_W;
    localparam int PROD_W   = c3zb_pkg::PROD_W;
    localparam int ROWSUM_W = c3zb_pkg::ROWSUM_W;
    localparam int SUM_W    = c3zb_pkg::SUM_W;

    logic [PIX_W-1:0]           win_reg     [TAPS][TAPS];
    c3zb_pkg::tap_ctl_t         ctl_a_reg;
    logic                       vld_a_reg;

    logic signed [PROD_W-1:0]   prod_next   [TAPS][TAPS];
    logic signed [PROD_W-1:0]   prod_reg    [TAPS][TAPS];
    logic                       vld_b_reg;
    logic                       last_b_reg;

    logic signed [ROWSUM_W-1:0] rowsum_next [TAPS];
    logic signed [ROWSUM_W-1:0] rowsum_reg  [TAPS];
    logic                       vld_c_reg;
    logic                       last_c_reg;

    logic signed [SUM_W-1:0]    sum_next;
    logic signed [SUM_W-1:0]    sum_reg;
    logic                       vld_d_reg;
    logic                       last_d_reg;

    logic [TAPS-1:0]            row_ok;
    logic [TAPS-1:0]            col_ok;
    logic [SUM_W-1:0]           scaled;

    // Window shift; column 0 is the newest pixel of each row.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int a = 0; a < TAPS; a++)
            begin
                for (int k = TAPS - 1; k > 0; k--)
                begin
                    win_reg[a][k] <= win_reg[a][k-1];
                end
                win_reg[a][0] <= col_in[a];
            end
            ctl_a_reg <= ctl_in;
        end
    end

    // Kernel row 0 meets the newest image row (the kernel is flipped).
    always_comb
    begin
        row_ok = {ctl_a_reg.row_lo_ok, 1'b1, ctl_a_reg.row_hi_ok};
        col_ok = {ctl_a_reg.col_lo_ok, 1'b1, ctl_a_reg.col_hi_ok};
        for (int r = 0; r < TAPS; r++)
        begin
            for (int k = 0; k < TAPS; k++)
            begin
                if (row_ok[r] && col_ok[k])
                begin
                    prod_next[r][k] = $signed(coef_rows[r][k*COEF_W +: COEF_W])
                                    * $signed({1'b0, win_reg[TAPS-1-r][k]});
                end
                else
                begin
                    prod_next[r][k] = '0;
                end
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < TAPS; r++)
        begin
            rowsum_next[r] = '0;
            for (int k = 0; k < TAPS; k++)
            begin
                rowsum_next[r] = rowsum_next[r] + ROWSUM_W'(prod_reg[r][k]);
            end
        end
        sum_next = '0;
        for (int r = 0; r < TAPS; r++)
        begin
            sum_next = sum_next + SUM_W'(rowsum_reg[r]);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        last_b_reg <= ctl_a_reg.last;
        rowsum_reg <= rowsum_next;
        last_c_reg <= last_b_reg;
        sum_reg    <= sum_next;
        last_d_reg <= last_c_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
        end
        else
        begin
            vld_a_reg <= shift_en && ctl_in.emit;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
            vld_d_reg <= vld_c_reg;
        end
    end

    // A positive sum shifts the same toward zero as toward minus infinity.
    always_comb
    begin
        scaled     = sum_reg >> c3zb_pkg::COEF_FRAC_BITS;
        beat.last  = last_d_reg;
        if (sum_reg[SUM_W-1] || (sum_reg == '0))
        begin
            beat.pixel = '0;
        end
        else if (|scaled[SUM_W-1:PIX_W])
        begin
            beat.pixel = '1;
        end
        else
        begin
            beat.pixel = scaled[PIX_W-1:0];
        end
    end

    assign push = vld_d_reg;

endmodule

// ===== rtl/core/c3zb_out_fifo.sv =====
//------------------------------------------------------------------------------
// 3x3 convolution filter: output queue
// Small queue of finished beats that absorbs the pipeline while the output
// side stalls; the credit count upstream keeps it from overflowing.
//------------------------------------------------------------------------------
module c3zb_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  c3zb_pkg::out_beat_t push_beat,
    input  logic                pop,
    output logic                valid,
    output c3zb_pkg::out_beat_t head
);

    localparam int FIFO_DEPTH = c3zb_pkg::FIFO_DEPTH;
    localparam int FIFO_AW    = c3zb_pkg::FIFO_AW;
    localparam int CRED_W     = c3zb_pkg::CRED_W;

    c3zb_pkg::out_beat_t beat_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CRED_W-1:0]   count_reg,  count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + FIFO_AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + FIFO_AW'(1);
        end
        count_next = count_reg + CRED_W'(push) - CRED_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            beat_mem[wr_ptr_reg] <= push_beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign valid = (count_reg != '0);
    assign head  = beat_mem[rd_ptr_reg];

endmodule

// ===== rtl/core/conv3x3_zero_border_filter_core.sv =====
//------------------------------------------------------------------------------
// 3x3 convolution filter core
// Streaming 3x3 flipped convolution of 8-bit pixels with zero border and
// signed Q8.8 coefficients, saturated to 0..255.
//------------------------------------------------------------------------------
// The core takes one beat per clock while input ready is high, pixels or
// flush steps in raster order, and gives one filtered pixel per beat once the
// stream is a row and a column ahead of the output; after the last pixel of a
// frame, width+1 flush beats drain the rest, and frame_last marks the final
// pixel. Sustained rate, while results are taken, is one beat per clock, set
// by the line buffer, which has one read port and one write port and is read
// once and written once per beat. A beat is registered into stage 1 with the
// line buffer read, then passes the window, product, row-sum and sum registers
// into an 8-beat output queue that rides out stalls, and input ready falls
// only when eight results are owed and not yet taken. The line buffer needs
// no clearing pass after reset: every window tap outside the current frame is
// masked by frame coordinates, so stale contents never reach the sum. Register
// writes belong in idle periods; a width or height write restarts the frame.
//------------------------------------------------------------------------------
module conv3x3_zero_border_filter_core (
    input  logic           clk,
    input  logic           rst_n,
    c3zb_pix_in_if.sink    pix_in,
    c3zb_pix_out_if.source pix_out,
    c3zb_cfg_if.sink       cfg
);

    localparam int WEFF_W     = c3zb_pkg::WEFF_W;
    localparam int WIDTH_W    = c3zb_pkg::WIDTH_W;
    localparam int HEIGHT_W   = c3zb_pkg::HEIGHT_W;
    localparam int PIX_W      = c3zb_pkg::PIX_W;
    localparam int COL_W      = c3zb_pkg::COL_W;
    localparam int LB_W       = c3zb_pkg::LB_W;
    localparam int ROW_COEF_W = c3zb_pkg::ROW_COEF_W;

    // Configuration registers.
    logic [WIDTH_W-1:0]    frame_width_reg;
    logic [HEIGHT_W-1:0]   frame_height_reg;
    logic [ROW_COEF_W-1:0] coef_top_reg;
    logic [ROW_COEF_W-1:0] coef_middle_reg;
    logic [ROW_COEF_W-1:0] coef_bottom_reg;

    logic                  cfg_wr;
    logic                  geom_wr;
    logic [WEFF_W-1:0]     w_eff;
    logic [HEIGHT_W-1:0]   h_eff;

    logic                  in_ready;
    logic                  accept;
    logic                  pop;
    logic [COL_W-1:0]      rd_col;
    c3zb_pkg::tap_ctl_t    ctl;
    logic [PIX_W-1:0]      px;

    // Stage 1: the beat is held here alongside the registered line buffer read.
    logic                  s1_vld_reg;
    logic [PIX_W-1:0]      s1_px_reg;
    logic [COL_W-1:0]      s1_col_reg;
    c3zb_pkg::tap_ctl_t    s1_ctl_reg;

    logic [LB_W-1:0]       lb_rd_data;
    logic [LB_W-1:0]       lb_wr_data;
    c3zb_pkg::tap_col_t    col_in;
    c3zb_pkg::coef_rows_t  coef_rows;

    logic                  mac_push;
    c3zb_pkg::out_beat_t   mac_beat;
    logic                  fifo_valid;
    c3zb_pkg::out_beat_t   fifo_head;

    // ---------------------------------------------------------------------
    // Register port. Writes are always taken; unknown indexes are dropped.
    // ---------------------------------------------------------------------
    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;
    assign geom_wr   = cfg_wr && ((cfg.index == c3zb_pkg::REG_FRAME_WIDTH) ||
                                  (cfg.index == c3zb_pkg::REG_FRAME_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= c3zb_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= c3zb_pkg::FRAME_HEIGHT_RST;
            coef_top_reg     <= c3zb_pkg::COEF_TOP_RST;
            coef_middle_reg  <= c3zb_pkg::COEF_MIDDLE_RST;
            coef_bottom_reg  <= c3zb_pkg::COEF_BOTTOM_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg.index)
                c3zb_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg.data[WIDTH_W-1:0];
                c3zb_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg.data[HEIGHT_W-1:0];
                c3zb_pkg::REG_COEF_TOP:     coef_top_reg     <= cfg.data[ROW_COEF_W-1:0];
                c3zb_pkg::REG_COEF_MIDDLE:  coef_middle_reg  <= cfg.data[ROW_COEF_W-1:0];
                c3zb_pkg::REG_COEF_BOTTOM:  coef_bottom_reg  <= cfg.data[ROW_COEF_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // A zero width or height acts as one; the width is capped at the
    // line buffer depth.
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w_eff = WEFF_W'(1);
        end
        else if (32'(frame_width_reg) > 32'(c3zb_pkg::MAX_WIDTH))
        begin
            w_eff = WEFF_W'(c3zb_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = WEFF_W'(frame_width_reg);
        end
        h_eff = (frame_height_reg == '0) ? HEIGHT_W'(1) : frame_height_reg;
    end

    // ---------------------------------------------------------------------
    // Input side. A flush step enters the window as a zero pixel.
    // ---------------------------------------------------------------------
    assign pix_in.ready = in_ready;
    assign accept       = pix_in.valid && in_ready;
    assign px           = (pix_in.cmd == c3zb_pkg::CMD_PIXEL) ? pix_in.pixel_in : '0;
    assign pop          = pix_out.valid && pix_out.ready;

    c3zb_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .geom_wr (geom_wr),
        .pop     (pop),
        .w_eff   (w_eff),
        .h_eff   (h_eff),
        .ready   (in_ready),
        .rd_col  (rd_col),
        .ctl     (ctl)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg  <= px;
            s1_col_reg <= rd_col;
            s1_ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= accept;
        end
    end

    // ---------------------------------------------------------------------
    // Line buffer: each column entry holds the row two back in the upper
    // byte and the row one back in the lower byte. The entry is read at
    // acceptance and rewritten from stage 1 with the rows moved up.
    // ---------------------------------------------------------------------
    assign lb_wr_data = {lb_rd_data[PIX_W-1:0], s1_px_reg};

    c3zb_line_buf u_line_buf (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (rd_col),
        .wr_en   (s1_vld_reg),
        .wr_addr (s1_col_reg),
        .wr_data (lb_wr_data),
        .rd_data (lb_rd_data)
    );

    assign col_in[0] = lb_rd_data[LB_W-1:PIX_W];
    assign col_in[1] = lb_rd_data[PIX_W-1:0];
    assign col_in[2] = s1_px_reg;

    assign coef_rows[0] = coef_top_reg;
    assign coef_rows[1] = coef_middle_reg;
    assign coef_rows[2] = coef_bottom_reg;

    c3zb_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (s1_vld_reg),
        .col_in    (col_in),
        .ctl_in    (s1_ctl_reg),
        .coef_rows (coef_rows),
        .push      (mac_push),
        .beat      (mac_beat)
    );

    // ---------------------------------------------------------------------
    // Output queue.
    // ---------------------------------------------------------------------
    c3zb_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (mac_push),
        .push_beat (mac_beat),
        .pop       (pop),
        .valid     (fifo_valid),
        .head      (fifo_head)
    );

    assign pix_out.valid      = fifo_valid;
    assign pix_out.pixel_out  = fifo_head.pixel;
    assign pix_out.frame_last = fifo_head.last;

endmodule

// ===== rtl/core/c3zb_checker.sv =====
//------------------------------------------------------------------------------
// 3x3 convolution filter: port checker
// Watches the core's channels over time and is bound to the top level.
//------------------------------------------------------------------------------
`include "conv3x3_zero_border_filter_core_macros.svh"

module c3zb_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [c3zb_pkg::PIX_W-1:0] out_pixel,
    input logic                       out_last
);

    `C3ZB_ASSERT_HOLD(a_out_valid_held, out_valid, out_ready, out_valid, "output beat withdrawn")
    `C3ZB_ASSERT_HOLD(a_out_beat_stable, out_valid, out_ready, $stable(out_pixel) && $stable(out_last), "stalled output beat changed")

    // Input back-pressure only comes from results that are owed, and some of
    // them must already sit in the output queue.
    `C3ZB_ASSERT(a_stall_has_backlog, !in_ready |-> out_valid, "input stalled with no output pending")

    // Only an output beat that is taken frees room for more input.
    `C3ZB_ASSERT(a_ready_after_pop, $rose(in_ready) |-> $past(out_valid && out_ready), "input ready rose without an output beat")

endmodule

bind conv3x3_zero_border_filter_core c3zb_checker u_c3zb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (pix_in.ready),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .out_pixel (pix_out.pixel_out),
    .out_last  (pix_out.frame_last)
);

// ===== tb/conv3x3_zero_border_filter_core_checker.sv =====
//------------------------------------------------------------------------------
// 3x3 convolution filter: stream checker
// Watches the register, pixel and result channels of the filter core. It keeps
// its own copy of the line buffer, window and frame counters, works out the
// filtered pixel that each beat taken in completes, if any, and compares each
// result beat with the oldest prediction.
//------------------------------------------------------------------------------
module conv3x3_zero_border_filter_core_checker
    import c3zb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    c3zb_pix_in_if  pix_in,
    c3zb_pix_out_if pix_out,
    c3zb_cfg_if     cfg,
    output int      fail_count,
    output int      owed
);

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    coef_rows_t          kernel;

    logic [PIX_W-1:0] line_mem [2*MAX_WIDTH];
    logic [PIX_W-1:0] win [TAPS][TAPS];
    int unsigned      src_row;
    int unsigned      src_col;
    int unsigned      dst_row;
    int unsigned      dst_col;

    out_beat_t expected_pixels [$];
    int        mismatches;

    function automatic void restart_frame();
        src_row = 0;
        src_col = 0;
        dst_row = 0;
        dst_col = 0;
    endfunction

    // Advances the stream by one position and queues the filtered pixel it
    // completes, if any.
    function automatic void filter_beat(input logic cmd_bit, input logic [PIX_W-1:0] value);
        longint           w;
        longint           h;
        longint           acc;
        longint           sr;
        longint           sc;
        longint           coef;
        int unsigned      slot;
        logic [PIX_W-1:0] px;
        logic             emit;
        out_beat_t        res;

        w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : longint'(width_reg);
        h = (height_reg == 0) ? 1 : longint'(height_reg);
        slot = src_col % MAX_WIDTH;
        px = (cmd_bit == CMD_PIXEL) ? value : '0;
        emit = (src_row >= 2) || (src_row == 1 && src_col >= 1);

        for (int r = 0; r < TAPS; r++)
        begin
            win[r][2] = win[r][1];
            win[r][1] = win[r][0];
        end
        win[0][0] = line_mem[MAX_WIDTH + slot];
        win[1][0] = line_mem[slot];
        win[2][0] = px;
        line_mem[MAX_WIDTH + slot] = line_mem[slot];
        line_mem[slot] = px;

        src_col++;
        if (src_col >= w)
        begin
            src_col = 0;
            src_row++;
        end

        if (emit)
        begin
            acc = 0;
            for (int r = 0; r < TAPS; r++)
            begin
                sr = longint'(dst_row) + 1 - r;
                if (sr >= 0 && sr < h)
                begin
                    for (int k = 0; k < TAPS; k++)
                    begin
                        sc = longint'(dst_col) + 1 - k;
                        if (sc >= 0 && sc < w)
                        begin
                            coef = longint'($signed(kernel[r][COEF_W*k +: COEF_W]));
                            acc += coef * longint'(win[TAPS-1-r][k]);
                        end
                    end
                end
            end
            if (acc <= 0)
                res.pixel = '0;
            else if ((acc >>> COEF_FRAC_BITS) > 255)
                res.pixel = 8'd255;
            else
                res.pixel = PIX_W'(acc >>> COEF_FRAC_BITS);
            res.last = (dst_row >= h - 1) && (dst_col >= w - 1);
            expected_pixels = {expected_pixels, res};

            if (res.last)
            begin
                restart_frame();
            end
            else
            begin
                dst_col++;
                if (dst_col >= w)
                begin
                    dst_col = 0;
                    dst_row++;
                end
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_beat_t want;

        if (!rst_n)
        begin
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            kernel[0]  = COEF_TOP_RST;
            kernel[1]  = COEF_MIDDLE_RST;
            kernel[2]  = COEF_BOTTOM_RST;
            for (int i = 0; i < 2*MAX_WIDTH; i++)
                line_mem[i] = '0;
            for (int r = 0; r < TAPS; r++)
                for (int k = 0; k < TAPS; k++)
                    win[r][k] = '0;
            restart_frame();
            expected_pixels.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_reg_t'(cfg.index))
                    REG_FRAME_WIDTH:
                    begin
                        width_reg = cfg.data[WIDTH_W-1:0];
                        restart_frame();
                    end
                    REG_FRAME_HEIGHT:
                    begin
                        height_reg = cfg.data[HEIGHT_W-1:0];
                        restart_frame();
                    end
                    REG_COEF_TOP:    kernel[0] = cfg.data[ROW_COEF_W-1:0];
                    REG_COEF_MIDDLE: kernel[1] = cfg.data[ROW_COEF_W-1:0];
                    REG_COEF_BOTTOM: kernel[2] = cfg.data[ROW_COEF_W-1:0];
                    default: ;
                endcase
            end

            if (pix_in.valid && pix_in.ready)
                filter_beat(pix_in.cmd, pix_in.pixel_in);

            if (pix_out.valid && pix_out.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: result beat with none expected, got pixel %0d last %0b",
                             $time, pix_out.pixel_out, pix_out.frame_last);
                    mismatches++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pix_out.pixel_out !== want.pixel)
                    begin
                        $display("%0t: pixel_out expected %0d, got %0d",
                                 $time, want.pixel, pix_out.pixel_out);
                        mismatches++;
                    end
                    if (pix_out.frame_last !== want.last)
                    begin
                        $display("%0t: frame_last expected %0b, got %0b",
                                 $time, want.last, pix_out.frame_last);
                        mismatches++;
                    end
                end
            end
        end
        fail_count <= mismatches;
        owed       <= expected_pixels.size();
    end

endmodule

// ===== tb/conv3x3_zero_border_filter_core_test.sv =====
//------------------------------------------------------------------------------
// 3x3 convolution filter: core testbench
// Drives pixel frames, flush beats and register writes into the filter core,
// stalls the result side on varying patterns, and lets the stream checker
// predict and compare every filtered pixel. Gives the final verdict.
//------------------------------------------------------------------------------
module conv3x3_zero_border_filter_core_test;
    import c3zb_pkg::*;

    // Random phases keep starting until at least ten have run and this many beats
    // have gone in, counting the directed and special frames as well.
    localparam int RANDOM_BEATS  = 1250;
    // Cycles with no beat on any channel before the run is declared hung.
    localparam int STALL_LIMIT   = 2000;
    // Pause after the last result so that beats with no result (the first row
    // and the next row's first beat) have left the six-stage pipeline.
    localparam int SETTLE_CYCLES = 16;
    // Length of the one long result-side hold-off.
    localparam int LONG_HOLD     = 300;
    // A register index past the end of the map; the core must ignore it.
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    typedef enum int {SINK_OPEN, SINK_MOSTLY, SINK_COIN, SINK_STARVED} sink_mode_t;

    logic clk;
    logic rst_n;

    c3zb_pix_in_if  pix_in ();
    c3zb_pix_out_if pix_out ();
    c3zb_cfg_if     cfg ();

    int fail_count;
    int owed;
    int quiet_cycles;
    int burst_left;
    int beats_sent;
    bit no_gaps;
    bit hold_off_req;

    conv3x3_zero_border_filter_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in),
        .pix_out (pix_out),
        .cfg     (cfg)
    );

    conv3x3_zero_border_filter_core_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_in     (pix_in),
        .pix_out    (pix_out),
        .cfg        (cfg),
        .fail_count (fail_count),
        .owed       (owed)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Any beat on any channel counts as progress. A long quiet stretch means
    // the core has hung or a prediction is never going to be met.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) ||
                (cfg.valid && cfg.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("%0t: watchdog: no beat moved for %0d cycles", $time, STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Result side. Ready follows one of several patterns for a random span,
    // from always open to nearly shut. When asked, it holds off for a long
    // stretch so that the output queue fills and the core stalls its input.
    initial
    begin : sink_side
        sink_mode_t mode;
        int         span;

        pix_out.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                pix_out.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                mode = sink_mode_t'($urandom_range(0, 3));
                span = $urandom_range(8, 64);
                for (int i = 0; i < span && !hold_off_req; i++)
                begin
                    case (mode)
                        SINK_OPEN:    pix_out.ready <= 1'b1;
                        SINK_MOSTLY:  pix_out.ready <= ($urandom_range(0, 3) != 0);
                        SINK_COIN:    pix_out.ready <= ($urandom_range(0, 1) == 1);
                        SINK_STARVED: pix_out.ready <= ($urandom_range(0, 9) == 0);
                        default:      pix_out.ready <= 1'b1;
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // Mostly arbitrary pixels, with a good share of the two extremes.
    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // Each kernel row is either arbitrary bits (mostly saturating) or three
    // coefficients of moderate size, which keep sums inside 0..255 often.
    function automatic coef_rows_t random_kernel();
        coef_rows_t k;
        int         c;

        for (int r = 0; r < TAPS; r++)
        begin
            if ($urandom_range(0, 3) == 0)
                k[r] = ROW_COEF_W'({$urandom, $urandom});
            else
                for (int t = 0; t < TAPS; t++)
                begin
                    c = int'($urandom_range(0, 320)) - 128;
                    k[r][COEF_W*t +: COEF_W] = COEF_W'(c);
                end
        end
        return k;
    endfunction

    // Offers one beat and returns at the edge where it is taken. The sender
    // works in bursts; a gap, when one is due, drops valid before the beat.
    // Valid stays high on return so that back-to-back beats need no toggling.
    task automatic send_beat(input logic cmd_bit, input logic [PIX_W-1:0] value);
        int gap;

        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = (no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                pix_in.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        pix_in.valid    <= 1'b1;
        pix_in.cmd      <= cmd_bit;
        pix_in.pixel_in <= value;
        @(posedge clk);
        while (!pix_in.ready) @(posedge clk);
        burst_left--;
        beats_sent++;
    endtask

    // Stops sending and waits until every predicted result has been taken,
    // then lets the pipeline settle. The checker updates its count at each
    // edge, so the loop waits for an edge before its first look.
    task automatic wait_idle();
        pix_in.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (owed != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register beat. Valid stays high; the caller lowers it after a batch.
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
    endtask

    // Geometry writes carry random bits above the register width, which the
    // core must drop. Either write restarts the frame.
    task automatic set_geometry(input int w_raw, input int h_raw);
        logic [CFG_DATA_W-1:0] wd;
        logic [CFG_DATA_W-1:0] hd;

        wd = CFG_DATA_W'({$urandom, $urandom});
        hd = CFG_DATA_W'({$urandom, $urandom});
        wd[WIDTH_W-1:0]  = WIDTH_W'(w_raw);
        hd[HEIGHT_W-1:0] = HEIGHT_W'(h_raw);
        put_reg(REG_FRAME_WIDTH, wd);
        put_reg(REG_FRAME_HEIGHT, hd);
        cfg.valid <= 1'b0;
    endtask

    // Loads all three kernel rows, then a write to an unmapped index that
    // must change nothing.
    task automatic set_kernel(input coef_rows_t k);
        put_reg(REG_COEF_TOP, CFG_DATA_W'(k[0]));
        put_reg(REG_COEF_MIDDLE, CFG_DATA_W'(k[1]));
        put_reg(REG_COEF_BOTTOM, CFG_DATA_W'(k[2]));
        put_reg(REG_NONE, CFG_DATA_W'({$urandom, $urandom}));
        cfg.valid <= 1'b0;
    endtask

    // A whole frame of w*h stream positions followed by the w+1 drain beats.
    // Some positions inside the frame may be flush beats (they count as a
    // zero pixel), and some drain positions may carry pixels that must never
    // reach a sum. Flush beats carry random bits in pixel_in.
    task automatic run_frame(input int w, input int h, input int flush_pct, input int stray_pct);
        for (int n = 0; n < w * h; n++)
        begin
            if ($urandom_range(0, 99) < flush_pct)
                send_beat(CMD_FLUSH, PIX_W'($urandom));
            else
                send_beat(CMD_PIXEL, rand_pixel());
        end
        for (int n = 0; n <= w; n++)
        begin
            if ($urandom_range(0, 99) < stray_pct)
                send_beat(CMD_PIXEL, rand_pixel());
            else
                send_beat(CMD_FLUSH, PIX_W'($urandom));
        end
    endtask

    // Part of a frame, left unfinished; the next geometry write restarts it.
    task automatic run_partial(input int beats);
        for (int n = 0; n < beats; n++)
            send_beat(($urandom_range(0, 9) == 0) ? CMD_FLUSH : CMD_PIXEL, rand_pixel());
    endtask

    initial
    begin : stimulus
        coef_rows_t k;
        int         phase;
        int         w_raw;
        int         h_raw;
        int         w;
        int         h;

        rst_n           <= 1'b0;
        pix_in.valid    <= 1'b0;
        pix_in.cmd      <= CMD_PIXEL;
        pix_in.pixel_in <= '0;
        cfg.valid       <= 1'b0;
        cfg.index       <= REG_FRAME_WIDTH;
        cfg.data        <= '0;
        quiet_cycles    <= 0;
        hold_off_req    = 1'b0;
        no_gaps         = 1'b0;
        burst_left      = 0;
        beats_sent      = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. First a small 3x2 frame under the kernel left by
        // reset, which is the identity.
        set_geometry(3, 2);
        run_frame(3, 2, 0, 0);
        wait_idle();

        // Zero width and height both mean one; every coefficient at its most
        // positive value drives the single output to saturation.
        k[0] = {TAPS{16'h7FFF}};
        k[1] = {TAPS{16'h7FFF}};
        k[2] = {TAPS{16'h7FFF}};
        set_geometry(0, 0);
        set_kernel(k);
        send_beat(CMD_PIXEL, 8'd255);
        send_beat(CMD_FLUSH, 8'd255);
        send_beat(CMD_FLUSH, 8'd0);
        wait_idle();

        // Most negative coefficients clamp every output to zero; flush beats
        // fall inside the frame.
        k[0] = {TAPS{16'h8000}};
        k[1] = {TAPS{16'h8000}};
        k[2] = {TAPS{16'h8000}};
        set_geometry(2, 2);
        set_kernel(k);
        send_beat(CMD_PIXEL, 8'd0);
        send_beat(CMD_FLUSH, 8'd170);
        send_beat(CMD_PIXEL, 8'd255);
        send_beat(CMD_FLUSH, 8'd85);
        run_frame(0, 0, 0, 0);
        wait_idle();

        // One pixel per row: the left and right neighbours are both outside
        // the frame. Every drain position carries a stray pixel.
        set_geometry(1, 3);
        set_kernel(random_kernel());
        run_frame(1, 3, 0, 100);

        // Random part. Each phase starts from an idle core, may load a new
        // kernel, always rewrites the geometry, and then sends a frame or a
        // piece of one. A few phases take the special shapes.
        for (phase = 0; phase < 10 || beats_sent < RANDOM_BEATS; phase++)
        begin
            wait_idle();
            no_gaps = ($urandom_range(0, 4) == 0);
            if (phase == 0 || $urandom_range(0, 1) == 1)
                set_kernel(random_kernel());
            case (phase)
                3:
                begin
                    // The result side shuts for a long stretch while the
                    // sender keeps offering beats without gaps.
                    set_geometry(24, 10);
                    no_gaps = 1'b1;
                    hold_off_req = 1'b1;
                    run_frame(24, 10, 5, 5);
                end
                5:
                begin
                    // Full width, abandoned before any output is due.
                    set_geometry(MAX_WIDTH, 3);
                    run_partial(40);
                end
                7:
                begin
                    // Width above the maximum clamps to it; a piece of the
                    // single row, abandoned before any output is due.
                    set_geometry(2047, 1);
                    run_partial(48);
                end
                9:
                begin
                    // Tall frame, one column wide.
                    set_geometry(1, 200);
                    run_frame(1, 200, 1, 1);
                end
                default:
                begin
                    w_raw = $urandom_range(0, 12);
                    h_raw = $urandom_range(0, 8);
                    w = (w_raw == 0) ? 1 : w_raw;
                    h = (h_raw == 0) ? 1 : h_raw;
                    set_geometry(w_raw, h_raw);
                    if ($urandom_range(0, 5) == 0)
                        run_partial($urandom_range(1, w * h + w));
                    else
                        run_frame(w, h, $urandom_range(0, 10), $urandom_range(0, 20));
                end
            endcase
        end

        wait_idle();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/c3zb_pkg.sv
rtl/core/c3zb_ifs.sv
rtl/core/c3zb_line_buf.sv
rtl/core/c3zb_ctrl.sv
rtl/core/c3zb_mac.sv
rtl/core/c3zb_out_fifo.sv
rtl/core/conv3x3_zero_border_filter_core.sv
rtl/core/c3zb_checker.sv
tb/conv3x3_zero_border_filter_core_checker.sv
tb/conv3x3_zero_border_filter_core_test.sv
